/* rtl/murmur3_32_stream_hash_defines.svh */
// Assertion macros for the checker file of the hash block.
`ifndef MURMUR3_32_STREAM_HASH_DEFINES_SVH
`define MURMUR3_32_STREAM_HASH_DEFINES_SVH

// Clocked assertion that is switched off while reset is asserted.
`define MM3_ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define MM3_ASSERT_RST(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/mm3_pkg.sv */
package mm3_pkg;

	// Hash constants.
	localparam logic [31:0] C1      = 32'hcc9e2d51;
	localparam logic [31:0] C2      = 32'h1b873593;
	localparam logic [31:0] MIX_ADD = 32'he6546b64;
	localparam logic [31:0] F1      = 32'h85ebca6b;
	localparam logic [31:0] F2      = 32'hc2b2ae35;

	// Byte counts of a full word and of an empty one.
	localparam logic [2:0] FULL_COUNT = 3'd4;
	localparam logic [2:0] NO_BYTES   = 3'd0;

	// Queue between the front and the back, depth is a power of two.
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = QPTR_W + 1;

	// One mixed key on its way to the back.
	typedef struct packed {
		logic [31:0] key;
		logic [2:0]  count;
		logic        last;
	} q_entry_t;

	// Queue status seen by both sides.
	typedef struct packed {
		logic not_empty;
		logic full;
	} q_status_t;

	// Back sequencer states.
	typedef enum logic [1:0] {
		ST_FOLD,
		ST_FIN1,
		ST_FIN2,
		ST_EMIT
	} back_state_t;

endpackage

/* rtl/mm3_queue.sv */
module mm3_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  mm3_pkg::q_entry_t push_entry,
	input  logic              pop,
	output mm3_pkg::q_entry_t head,
	output mm3_pkg::q_status_t status
);
	import mm3_pkg::*;

	q_entry_t            entries_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                do_push;
	logic                do_pop;

	// A push is dropped when full and a pop when empty; callers never ask for either.
	assign status.full      = (count_q == QCNT_W'(QDEPTH));
	assign status.not_empty = (count_q != '0);
	assign do_push          = push && !status.full;
	assign do_pop           = pop && status.not_empty;
	assign head             = entries_q[rd_ptr_q];

	// Entry storage needs no reset.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

/* rtl/mm3_front.sv */
module mm3_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [31:0]        data_word,
	input  logic [2:0]         byte_count,
	input  logic               last,
	input  mm3_pkg::q_status_t q_status,
	output logic               push,
	output mm3_pkg::q_entry_t  push_entry
);
	import mm3_pkg::*;

	logic        valid_s1;
	logic [31:0] prod_s1;
	logic [2:0]  count_s1;
	logic        last_s1;
	logic        valid_s2;
	logic [31:0] key_s2;
	logic [2:0]  count_s2;
	logic        last_s2;
	logic        advance;
	logic [2:0]  count_eff;
	logic [31:0] byte_mask;
	logic [31:0] rot_s1;

	// The whole pipeline moves unless the key in the second stage cannot enter the queue.
	assign advance  = !valid_s2 || !q_status.full;
	assign in_ready = advance;
	assign push     = valid_s2 && !q_status.full;

	assign push_entry.key   = key_s2;
	assign push_entry.count = count_s2;
	assign push_entry.last  = last_s2;

	// Classify the word: only a last word may be short, counts above four saturate.
	always_comb begin
		if (!last) begin
			count_eff = FULL_COUNT;
		end else begin
			case (byte_count) inside
				[3'd4:3'd7]: count_eff = FULL_COUNT;
				default:     count_eff = byte_count;
			endcase
		end
	end

	// Keep only the valid bytes of a short word.
	always_comb begin
		case (count_eff)
			3'd1:    byte_mask = 32'h0000_00ff;
			3'd2:    byte_mask = 32'h0000_ffff;
			3'd3:    byte_mask = 32'h00ff_ffff;
			default: byte_mask = 32'hffff_ffff;
		endcase
	end

	assign rot_s1 = {prod_s1[16:0], prod_s1[31:17]};

	// Valid bits of the key mix stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	// Key mix: first multiply, then rotate by 15 and second multiply.
	always_ff @(posedge clk) begin
		if (advance) begin
			prod_s1  <= (data_word & byte_mask) * C1;
			count_s1 <= count_eff;
			last_s1  <= last;
			key_s2   <= rot_s1 * C2;
			count_s2 <= count_s1;
			last_s2  <= last_s1;
		end
	end

endmodule

/* rtl/mm3_back.sv */
module mm3_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               seed_we,
	input  logic [31:0]        seed,
	input  mm3_pkg::q_entry_t  head,
	input  mm3_pkg::q_status_t q_status,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [31:0]        hash
);
	import mm3_pkg::*;

	back_state_t state_q;
	back_state_t state_d;
	logic [31:0] seed_q;
	logic [31:0] hash_q;
	logic [31:0] total_q;
	logic        in_msg_q;
	logic        out_valid_q;
	logic [31:0] out_hash_q;
	logic        load_out;
	logic [31:0] base_h;
	logic [31:0] base_t;
	logic [31:0] mixed;
	logic [31:0] rot13;
	logic [31:0] folded;
	logic [31:0] total_new;
	logic [31:0] shr16;
	logic [31:0] shr13;

	assign out_valid = out_valid_q;
	assign hash      = out_hash_q;

	// Next state of the fold and finalizer sequencer.
	always_comb begin
		case (state_q)
			ST_FOLD: state_d = (q_status.not_empty && head.last) ? ST_FIN1 : ST_FOLD;
			ST_FIN1: state_d = ST_FIN2;
			ST_FIN2: state_d = ST_EMIT;
			ST_EMIT: state_d = (!out_valid_q || out_ready) ? ST_FOLD : ST_EMIT;
			default: state_d = ST_FOLD;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		pop      = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ST_FOLD: pop      = q_status.not_empty;
			ST_EMIT: load_out = !out_valid_q || out_ready;
			default: begin
				pop      = 1'b0;
				load_out = 1'b0;
			end
		endcase
	end

	// Hash fold of one key; a new message starts from the seed.
	assign base_h    = in_msg_q ? hash_q : seed_q;
	assign base_t    = in_msg_q ? total_q : 32'd0;
	assign mixed     = base_h ^ head.key;
	assign rot13     = {mixed[18:0], mixed[31:19]};
	assign total_new = base_t + {29'd0, head.count};

	always_comb begin
		if (head.count == FULL_COUNT) begin
			folded = rot13 + {rot13[29:0], 2'b00} + MIX_ADD;
		end else if (head.count == NO_BYTES) begin
			folded = base_h;
		end else begin
			folded = mixed;
		end
	end

	assign shr16 = {16'd0, hash_q[31:16]};
	assign shr13 = {13'd0, hash_q[31:13]};

	// Control registers and the seed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_FOLD;
			seed_q      <= 32'd0;
			in_msg_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (seed_we) begin
				seed_q <= seed;
			end
			if (pop) begin
				in_msg_q <= !head.last;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Running hash, byte total and finalizer steps share the hash register; ST_EMIT loads the output hash.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_FOLD: begin
				if (pop) begin
					total_q <= total_new;
					hash_q  <= head.last ? (folded ^ total_new) : folded;
				end
			end
			ST_FIN1: hash_q <= (hash_q ^ shr16) * F1;
			ST_FIN2: hash_q <= (hash_q ^ shr13) * F2;
			default: begin
				if (load_out) begin
					out_hash_q <= hash_q ^ shr16;
				end
			end
		endcase
	end

endmodule

/* rtl/murmur3_32_stream_hash.sv */
// MurmurHash3 x86_32 over a stream of little-endian words, seed from a config register.
// Throughput: one word per cycle, set by the back fold; after a last word the fold waits
// for the two finalizer multiplies, the output load and a free output register.
// The last word passes s1, s2, queue, fold, FIN1, FIN2 and EMIT to the output register.
// Reset (arst_n low, asynchronous): pipeline, queue and output empty, seed cleared to zero.
module murmur3_32_stream_hash (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        seed_we,
	input  logic [31:0] seed,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] data_word,
	input  logic [2:0]  byte_count,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] hash
);
	import mm3_pkg::*;

	q_entry_t  push_entry;
	q_entry_t  head;
	q_status_t q_status;
	logic      push;
	logic      pop;

	// Front: accept, classify and key mix.
	mm3_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_word  (data_word),
		.byte_count (byte_count),
		.last       (last),
		.q_status   (q_status),
		.push       (push),
		.push_entry (push_entry)
	);

	// Queue of mixed keys.
	mm3_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.status     (q_status)
	);

	// Back: hash fold, length fold, finalizer and output register.
	mm3_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.seed_we   (seed_we),
		.seed      (seed),
		.head      (head),
		.q_status  (q_status),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.hash      (hash)
	);

endmodule

/* rtl/mm3_checker.sv */
`include "murmur3_32_stream_hash_defines.svh"

module mm3_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        last,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] hash
);

	// A stalled result stays put.
	`MM3_ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(hash), "result changed while stalled")

	// A word that waits for the block stays offered with the same last flag.
	`MM3_ASSERT_CLK(a_in_hold, in_valid && !in_ready |=> in_valid && $stable(last), "input changed while stalled")

	// No result is shown while reset is asserted.
	`MM3_ASSERT_RST(a_out_reset, !arst_n |-> !out_valid, "result valid during reset")

	// The first edge after reset cannot show a result, since none has been computed.
	`MM3_ASSERT_RST(a_out_after_reset, !$past(arst_n) |-> !out_valid, "result valid right after reset")

endmodule

bind murmur3_32_stream_hash mm3_checker u_mm3_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.last      (last),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.hash      (hash)
);

/* sim/murmur3_32_stream_hash_tb.sv */
module murmur3_32_stream_hash_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam real CLK_PERIOD = 4.0;
	localparam int RESET_CYCLES = 6;

	// Mixing and finalizer constants of the 32-bit hash.
	localparam logic [31:0] KEY_MUL1 = 32'hcc9e2d51;
	localparam logic [31:0] KEY_MUL2 = 32'h1b873593;
	localparam logic [31:0] FOLD_ADD = 32'he6546b64;
	localparam logic [31:0] FIN_MUL1 = 32'h85ebca6b;
	localparam logic [31:0] FIN_MUL2 = 32'hc2b2ae35;
	localparam logic [2:0] FULL_WORD = 3'd4;
	localparam logic [2:0] EMPTY_WORD = 3'd0;

	localparam int ITEM_TARGET = 1950;
	localparam int RANDOM_PHASES = 6;
	localparam int SETTLE_CYCLES = 20;
	localparam int LONG_HOLD = 300;
	localparam int FLOOD_MESSAGES = 40;

	logic clk = 1'b0;
	logic arst_n;
	logic seed_we = 1'b0;
	logic [31:0] seed = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [31:0] data_word = '0;
	logic [2:0] byte_count = '0;
	logic last = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [31:0] hash;

	// Shadow copy of the seed register and of the message being hashed.
	logic [31:0] seed_copy = '0;
	logic [31:0] msg_hash = '0;
	logic [31:0] msg_bytes = '0;
	bit msg_open = 1'b0;
	logic [31:0] pending_hashes[$];

	int errors = 0;
	int words_sent = 0;
	int messages_sent = 0;
	int hashes_checked = 0;
	bit tx_no_gaps = 1'b0;
	bit hold_req = 1'b0;
	int stall_left = 0;
	int rx_cycle = 0;

	murmur3_32_stream_hash dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.seed_we   (seed_we),
		.seed      (seed),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_word (data_word),
		.byte_count(byte_count),
		.last      (last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.hash      (hash)
	);

	always #(CLK_PERIOD / 2.0) clk = ~clk;

	function automatic logic [31:0] rotl32(input logic [31:0] v, input int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic logic [31:0] scramble_key(input logic [31:0] k);
		logic [31:0] t;
		t = k * KEY_MUL1;
		t = rotl32(t, 15);
		return t * KEY_MUL2;
	endfunction

	function automatic logic [31:0] avalanche(input logic [31:0] h);
		logic [31:0] t;
		t = h ^ (h >> 16);
		t = t * FIN_MUL1;
		t = t ^ (t >> 13);
		t = t * FIN_MUL2;
		return t ^ (t >> 16);
	endfunction

	// Fold one transferred word into the shadow hash; a last word queues the final value.
	function automatic void absorb_word(input logic [31:0] w, input logic [2:0] cnt,
			input logic is_last);
		logic [2:0] n;
		logic [31:0] mask;
		if (!msg_open) begin
			msg_hash = seed_copy;
			msg_bytes = '0;
			msg_open = 1'b1;
		end
		// Only the last word may be short, and counts above four saturate.
		n = (!is_last || cnt > FULL_WORD) ? FULL_WORD : cnt;
		if (n == FULL_WORD) begin
			msg_hash = rotl32(msg_hash ^ scramble_key(w), 13);
			msg_hash = msg_hash * 32'd5 + FOLD_ADD;
		end else if (n != EMPTY_WORD) begin
			mask = (32'h1 << (8 * n)) - 32'h1;
			msg_hash = msg_hash ^ scramble_key(w & mask);
		end
		msg_bytes = msg_bytes + 32'(n);
		if (is_last) begin
			pending_hashes.insert(pending_hashes.size(), avalanche(msg_hash ^ msg_bytes));
			msg_open = 1'b0;
		end
	endfunction

	// Follow seed writes and input transfers, and check every hash transfer.
	always @(posedge clk) begin : hash_check
		logic [31:0] want;
		if (arst_n) begin
			if (seed_we)
				seed_copy = seed;
			if (in_valid && in_ready)
				absorb_word(data_word, byte_count, last);
			if (out_valid && out_ready) begin
				if (pending_hashes.size() == 0) begin
					errors++;
					$display("%0t: hash %h transferred with no message pending", $time, hash);
				end else begin
					want = pending_hashes.pop_front();
					hashes_checked++;
					if (hash !== want) begin
						errors++;
						$display("%0t: hash mismatch, expected %h, actual %h", $time, want, hash);
					end
				end
			end
		end
	end

	// Output side: steady windows, short and occasional longer random stalls, and a long hold on request.
	always @(posedge clk) begin : hash_sink
		int r;
		rx_cycle++;
		if (hold_req) begin
			hold_req = 1'b0;
			stall_left = LONG_HOLD;
		end
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else if (rx_cycle % 512 < 128) begin
			out_ready <= 1'b1;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 75) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b0;
				stall_left = (r < 96) ? $urandom_range(0, 2) : $urandom_range(10, 40);
			end
		end
	end

	function automatic int pick_gap();
		int r;
		if (tx_no_gaps)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 94)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [31:0] pick_word();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return 32'h0;
		if (r < 10)
			return 32'hffffffff;
		if (r < 15)
			return 32'h1 << $urandom_range(0, 31);
		return $urandom();
	endfunction

	// Offer one word and hold it until the transfer happens.
	task automatic send_word(input logic [31:0] w, input logic [2:0] cnt, input logic is_last);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_word <= w;
		byte_count <= cnt;
		last <= is_last;
		do @(posedge clk); while (!in_ready);
		words_sent++;
		if (is_last)
			messages_sent++;
	endtask

	// Stop offering words until every pending hash has arrived and the block is quiet.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_hashes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_seed(input logic [31:0] v);
		drain();
		seed_we <= 1'b1;
		seed <= v;
		@(posedge clk);
		seed_we <= 1'b0;
	endtask

	// A message of random length; stray counts on body words and odd tail counts are noise.
	task automatic send_random_message();
		int words;
		int r;
		logic [2:0] cnt;
		r = $urandom_range(0, 99);
		words = (r < 85) ? $urandom_range(0, 6) : $urandom_range(7, 60);
		tx_no_gaps = ($urandom_range(0, 4) == 0);
		repeat (words) begin
			cnt = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : FULL_WORD;
			send_word(pick_word(), cnt, 1'b0);
		end
		r = $urandom_range(0, 99);
		cnt = (r < 85) ? 3'($urandom_range(1, 4)) : 3'($urandom_range(0, 7));
		send_word(pick_word(), cnt, 1'b1);
	endtask

	// Tail lengths, masking of unused bytes, saturated counts and empty messages, seed at reset.
	task automatic test_directed_words();
		tx_no_gaps = 1'b0;
		send_word(32'hffffffff, EMPTY_WORD, 1'b1);
		send_word(32'hffffffff, 3'd1, 1'b1);
		send_word(32'ha5a5a5a5, 3'd2, 1'b1);
		send_word(32'h00000000, 3'd3, 1'b1);
		send_word(32'hffffffff, FULL_WORD, 1'b1);
		send_word(32'h0f1e2d3c, 3'd5, 1'b1);
		send_word(32'h0f1e2d3c, 3'd6, 1'b1);
		send_word(32'h0f1e2d3c, 3'd7, 1'b1);
		send_word(32'h12345678, FULL_WORD, 1'b0);
		send_word(32'h9abcdef0, FULL_WORD, 1'b1);
		// Body words ignore their count.
		send_word(32'h00000000, EMPTY_WORD, 1'b0);
		send_word(32'hffffffff, 3'd7, 1'b0);
		send_word(32'hdeadbeef, 3'd3, 1'b1);
		// Full body followed by an empty last word.
		send_word(32'h01020304, FULL_WORD, 1'b0);
		send_word(32'h00000000, EMPTY_WORD, 1'b1);
	endtask

	task automatic test_seed_extremes();
		logic [31:0] seeds[4];
		seeds = '{32'hffffffff, 32'h80000000, 32'h00000001, 32'h00000000};
		foreach (seeds[i]) begin
			write_seed(seeds[i]);
			send_word(32'hc0ffee11, FULL_WORD, 1'b0);
			send_word(32'h00abcdef, 3'd3, 1'b1);
			send_word(32'h00000000, EMPTY_WORD, 1'b1);
		end
	endtask

	// The sender goes quiet in the middle of a message, then finishes it.
	task automatic test_idle_mid_message();
		send_word(32'h11111111, FULL_WORD, 1'b0);
		send_word(32'h22222222, FULL_WORD, 1'b0);
		drain();
		send_word(32'h33333333, 3'd2, 1'b1);
	endtask

	// The sink holds off while short messages keep arriving, so the block fills and stalls.
	task automatic test_output_backpressure();
		drain();
		hold_req = 1'b1;
		tx_no_gaps = 1'b1;
		repeat (FLOOD_MESSAGES)
			send_word(pick_word(), 3'($urandom_range(0, 7)), 1'b1);
		repeat (10)
			send_random_message();
		drain();
	endtask

	task automatic test_random_traffic();
		int budget;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			write_seed($urandom());
			budget = words_sent + (ITEM_TARGET - words_sent) / (RANDOM_PHASES - phase);
			while (words_sent < budget)
				send_random_message();
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_words();
		test_seed_extremes();
		test_idle_mid_message();
		test_output_backpressure();
		test_random_traffic();
		drain();
		$display("Sent %0d words in %0d messages and checked %0d hashes.",
			words_sent, messages_sent, hashes_checked);
		$display("Seeds at both extremes and random, tails of 0 to 7 bytes, %0d-cycle sink hold.",
			LONG_HOLD);
		if (errors == 0)
			$display("murmur3_32_stream_hash_tb OK");
		else
			$display("murmur3_32_stream_hash_tb NOT OK");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#20_000_000;
		$display("murmur3_32_stream_hash_tb NOT OK");
		$finish;
	end

endmodule
